/* rtl/ercp_pkg.sv */
// ----------------------------------------------------------------------------
// ercp_pkg: shared types and constants of the rotated cube projector
// Configuration struct, register indexes, CORDIC constants and cube corners.
// ----------------------------------------------------------------------------
package ercp_pkg;

  typedef struct packed {
    logic signed [4:0] z_offset;
    logic [7:0]        scale;
    logic [7:0]        center_x;
    logic [7:0]        center_y;
  } cfg_t;

  localparam logic [7:0] REG_Z_OFFSET = 8'd0;
  localparam logic [7:0] REG_SCALE    = 8'd1;
  localparam logic [7:0] REG_CENTER_X = 8'd2;
  localparam logic [7:0] REG_CENTER_Y = 8'd3;

  localparam logic signed [4:0] Z_OFFSET_RST = -5'sd4;
  localparam logic [7:0]        SCALE_RST    = 8'd100;
  localparam logic [7:0]        CENTER_X_RST = 8'd64;
  localparam logic [7:0]        CENTER_Y_RST = 8'd80;

  localparam logic [63:0]        PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic signed [34:0] PI_Q30      = 35'sh0C90FDAA2;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sh06487ED51;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  function automatic logic [31:0] atan_q30(input logic [3:0] i);
    case (i)
      4'd0:  atan_q30 = 32'h3243F6A8;
      4'd1:  atan_q30 = 32'h1DAC6705;
      4'd2:  atan_q30 = 32'h0FADBAFC;
      4'd3:  atan_q30 = 32'h07F56EA6;
      4'd4:  atan_q30 = 32'h03FEAB76;
      4'd5:  atan_q30 = 32'h01FFD55B;
      4'd6:  atan_q30 = 32'h00FFFAAA;
      4'd7:  atan_q30 = 32'h007FFF55;
      4'd8:  atan_q30 = 32'h003FFFEA;
      4'd9:  atan_q30 = 32'h001FFFFD;
      4'd10: atan_q30 = 32'h000FFFFF;
      4'd11: atan_q30 = 32'h0007FFFF;
      4'd12: atan_q30 = 32'h0003FFFF;
      4'd13: atan_q30 = 32'h0001FFFF;
      4'd14: atan_q30 = 32'h0000FFFF;
      default: atan_q30 = 32'h00007FFF;
    endcase
  endfunction

  // corner sign flags {x_neg, y_neg, z_neg}
  function automatic logic [2:0] corner_neg(input logic [2:0] k);
    case (k)
      3'd0: corner_neg = 3'b110;
      3'd1: corner_neg = 3'b010;
      3'd2: corner_neg = 3'b000;
      3'd3: corner_neg = 3'b100;
      3'd4: corner_neg = 3'b111;
      3'd5: corner_neg = 3'b011;
      3'd6: corner_neg = 3'b001;
      default: corner_neg = 3'b101;
    endcase
  endfunction

endpackage

/* rtl/ercp_if.sv */
// ----------------------------------------------------------------------------
// ercp_if: channel interfaces of the rotated cube projector
// Encoder sample input, vertex output and configuration write channels.
// ----------------------------------------------------------------------------
interface ercp_in_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dt_level;
  modport source (output valid, clk_level, dt_level, input ready);
  modport sink (input valid, clk_level, dt_level, output ready);
endinterface

interface ercp_out_if #(parameter int COORD_BITS = 11);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   vertex_index;
  logic signed [COORD_BITS-1:0] screen_x;
  logic signed [COORD_BITS-1:0] screen_y;
  logic                         angle_changed;
  logic                         last;
  modport source (output valid, vertex_index, screen_x, screen_y, angle_changed, last,
                  input ready);
  modport sink (input valid, vertex_index, screen_x, screen_y, angle_changed, last,
                output ready);
endinterface

interface ercp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ercp_front.sv */
// ----------------------------------------------------------------------------
// ercp_front: encoder edge detection and angle accumulation
// Tracks the encoder clock level, steps and wraps the angle, queues the work.
// ----------------------------------------------------------------------------
module ercp_front
  import ercp_pkg::*;
#(
  parameter int AF = 16
) (
  input  logic            clk,
  input  logic            rst,
  ercp_in_if.sink         src,
  output logic            push_valid,
  output logic [AF+4:0]   push_data,
  input  logic            push_ready
);

  localparam int AW = AF + 4;
  localparam logic [63:0] PI_W  = (PI_Q60 + (64'd1 << (59 - AF))) >> (60 - AF);
  localparam logic [63:0] TPI_W = (PI_Q60 + (64'd1 << (58 - AF))) >> (59 - AF);
  localparam logic [63:0] STP_W = ((64'd1 << AF) + 64'd2) / 64'd5;
  localparam logic signed [AW-1:0] PI_QF     = PI_W[AW-1:0];
  localparam logic signed [AW-1:0] TWO_PI_QF = TPI_W[AW-1:0];
  localparam logic signed [AW-1:0] STEP_QF   = STP_W[AW-1:0];

  logic                 prev_clk;
  logic signed [AW-1:0] angle;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] wrapped;
  logic                 fall;

  always_comb begin
    fall = (src.clk_level != prev_clk) && !src.clk_level;
    sum  = src.dt_level ? angle + STEP_QF : angle - STEP_QF;
    if (sum >= PI_QF) begin
      wrapped = sum - TWO_PI_QF;
    end else if (sum < -PI_QF) begin
      wrapped = sum + TWO_PI_QF;
    end else begin
      wrapped = sum;
    end
  end

  assign src.ready  = push_ready;
  assign push_valid = src.valid;
  assign push_data  = {fall ? wrapped : angle, fall};

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_clk <= 1'b1;
      angle    <= '0;
    end else if (src.valid && push_ready) begin
      prev_clk <= src.clk_level;
      if (fall) begin
        angle <= wrapped;
      end
    end
  end

endmodule

/* rtl/ercp_queue.sv */
// ----------------------------------------------------------------------------
// ercp_queue: two-entry queue between front and back
// Holds stepped angles and their change flags.
// ----------------------------------------------------------------------------
module ercp_queue #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  input  logic         pop
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/ercp_back.sv */
// ----------------------------------------------------------------------------
// ercp_back: CORDIC sin/cos and per-vertex perspective projection
// Sequential CORDIC, then for each corner and axis a multiply and a
// restoring divider with rounding and saturation, into an output register.
// ----------------------------------------------------------------------------
module ercp_back
  import ercp_pkg::*;
#(
  parameter int AF = 16,
  parameter int CB = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  logic [AF+4:0] q_data,
  output logic          q_pop,
  ercp_out_if.source    dst
);

  localparam int AW = AF + 4;
  localparam int NW = 49 + CB;
  localparam int BW = $clog2(CB);
  localparam logic [CB-1:0] MAXV = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] MINV = {1'b1, {(CB-1){1'b0}}};
  localparam logic [BW-1:0] BIT_TOP = BW'(CB - 1);

  typedef enum logic [3:0] {
    B_IDLE, B_CORDIC, B_FOLD, B_TERM, B_PROD, B_PREP, B_DIVSET, B_DIV, B_SAT, B_EMIT
  } state_t;

  state_t               state;
  logic signed [34:0]   ang_a;
  logic signed [33:0]   cx;
  logic signed [33:0]   cy;
  logic [3:0]           iter;
  logic                 neg;
  logic                 changed;
  logic signed [33:0]   s_r;
  logic signed [33:0]   c_r;
  logic [2:0]           k;
  logic                 axis;
  logic signed [36:0]   den_r;
  logic signed [35:0]   num_r;
  logic signed [45:0]   term;
  logic [36:0]          dmag;
  logic                 dneg;
  logic                 dzero;
  logic signed [46:0]   p;
  logic [NW-1:0]        rem;
  logic [NW-1:0]        dsh;
  logic [CB-1:0]        quot;
  logic                 ovf;
  logic [BW-1:0]        bitc;
  logic [CB-1:0]        x_res;
  logic [CB-1:0]        y_res;

  logic                 o_valid;
  logic [2:0]           o_idx;
  logic [CB-1:0]        o_x;
  logic [CB-1:0]        o_y;
  logic                 o_chg;
  logic                 o_last;
  logic                 emit;

  logic signed [AW-1:0] q_ang;
  logic signed [34:0]   a0;
  logic signed [33:0]   xs;
  logic signed [33:0]   ys;
  logic signed [34:0]   atn;
  logic [2:0]           f;
  logic signed [34:0]   sv;
  logic signed [34:0]   cv;
  logic signed [34:0]   rz;
  logic signed [34:0]   nx;
  logic signed [36:0]   den;
  logic [7:0]           cent;
  logic [44:0]          cd;
  logic [46:0]          pabs;
  logic [NW-1:0]        nn;
  logic [NW-1:0]        d2;
  logic [CB-1:0]        res;

  assign q_ang = q_data[AW:1];
  assign q_pop = (state == B_IDLE) && q_valid;
  // output register loads when empty or being drained this cycle
  assign emit  = (state == B_EMIT) && (!o_valid || dst.ready);

  always_comb begin
    a0   = {{(35-AW){q_ang[AW-1]}}, q_ang} <<< (30 - AF);
    xs   = cx >>> iter;
    ys   = cy >>> iter;
    atn  = $signed({3'b000, atan_q30(iter)});
    f    = corner_neg(k);
    sv   = 35'(s_r);
    cv   = 35'(c_r);
    rz   = (f[2] ? -sv : sv) + (f[0] ? -cv : cv);
    nx   = (f[2] ? -cv : cv) - (f[0] ? -sv : sv);
    den  = 37'(rz) + (37'(cfg.z_offset) <<< 30);
    cent = axis ? cfg.center_y : cfg.center_x;
    cd   = dmag * 45'(cent);
    pabs = p[46] ? 47'(-p) : 47'(p);
    nn   = NW'({pabs, 1'b0}) + NW'(dmag);
    d2   = NW'({dmag, 1'b0});
    if (dzero) begin
      if (term > 0) begin
        res = MAXV;
      end else if (term < 0) begin
        res = MINV;
      end else begin
        res = CB'(cent);
      end
    end else if (!p[46]) begin
      res = (ovf || quot[CB-1]) ? MAXV : quot;
    end else begin
      res = (ovf || (quot > MINV)) ? MINV : -quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      o_valid <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (o_valid && dst.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            changed <= q_data[0];
            cx      <= CORDIC_GAIN;
            cy      <= '0;
            iter    <= '0;
            if (a0 > HALF_PI_Q30) begin
              ang_a <= a0 - PI_Q30;
              neg   <= 1'b1;
            end else if (a0 < -HALF_PI_Q30) begin
              ang_a <= a0 + PI_Q30;
              neg   <= 1'b1;
            end else begin
              ang_a <= a0;
              neg   <= 1'b0;
            end
            state <= B_CORDIC;
          end
        end
        B_CORDIC: begin
          if (!ang_a[34]) begin
            cx    <= cx - ys;
            cy    <= cy + xs;
            ang_a <= ang_a - atn;
          end else begin
            cx    <= cx + ys;
            cy    <= cy - xs;
            ang_a <= ang_a + atn;
          end
          iter <= iter + 4'd1;
          if (iter == 4'd15) begin
            state <= B_FOLD;
          end
        end
        B_FOLD: begin
          s_r   <= neg ? -cy : cy;
          c_r   <= neg ? -cx : cx;
          k     <= '0;
          axis  <= 1'b0;
          state <= B_TERM;
        end
        B_TERM: begin
          den_r <= den;
          if (axis) begin
            num_r <= f[1] ? -(36'sd1 <<< 30) : (36'sd1 <<< 30);
          end else begin
            num_r <= 36'(nx);
          end
          state <= B_PROD;
        end
        B_PROD: begin
          term  <= 46'(num_r) * $signed({38'd0, cfg.scale});
          dmag  <= den_r[36] ? 37'(-den_r) : 37'(den_r);
          dneg  <= den_r[36];
          dzero <= (den_r == '0);
          state <= B_PREP;
        end
        B_PREP: begin
          p     <= $signed({2'b00, cd}) + (dneg ? -47'(term) : 47'(term));
          state <= B_DIVSET;
        end
        B_DIVSET: begin
          ovf   <= (nn >= (d2 << CB));
          rem   <= nn;
          dsh   <= d2 << (CB - 1);
          quot  <= '0;
          bitc  <= BIT_TOP;
          state <= B_DIV;
        end
        B_DIV: begin
          if (rem >= dsh) begin
            rem  <= rem - dsh;
            quot <= {quot[CB-2:0], 1'b1};
          end else begin
            quot <= {quot[CB-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (bitc == '0) begin
            state <= B_SAT;
          end else begin
            bitc <= bitc - 1'b1;
          end
        end
        B_SAT: begin
          if (!axis) begin
            x_res <= res;
            axis  <= 1'b1;
            state <= B_TERM;
          end else begin
            y_res <= res;
            state <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (emit) begin
            o_idx   <= k;
            o_x     <= x_res;
            o_y     <= y_res;
            o_chg   <= changed;
            o_last  <= (k == 3'd7);
            axis    <= 1'b0;
            if (k == 3'd7) begin
              state <= B_IDLE;
            end else begin
              k     <= k + 3'd1;
              state <= B_TERM;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign dst.valid         = o_valid;
  assign dst.vertex_index  = o_idx;
  assign dst.screen_x      = o_x;
  assign dst.screen_y      = o_y;
  assign dst.angle_changed = o_chg;
  assign dst.last          = o_last;

endmodule

/* rtl/encoder_rotated_cube_projector_unit.sv */
// ----------------------------------------------------------------------------
// encoder_rotated_cube_projector_unit: encoder driven rotated cube projector
// Steps a Y-axis rotation angle from encoder samples and projects the cube.
// ----------------------------------------------------------------------------
// Sequence: CORDIC and FOLD per input, then for each vertex and axis the TERM, PROD,
//   PREP, DIVSET, DIV loop and SAT states, then EMIT into the output register.
// Throughput: one input per run; two inputs queue while a run is in progress.
// Reset: synchronous, clears angle, encoder level (high), queue, output and
//   configuration registers to their defaults.
module encoder_rotated_cube_projector_unit
  import ercp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int COORD_BITS      = 11
) (
  input  logic       clk,
  input  logic       rst,
  ercp_in_if.sink    src,
  ercp_out_if.source dst,
  ercp_cfg_if.sink   cfg
);

  localparam int QW = ANGLE_FRAC_BITS + 5;

  cfg_t          regs;
  logic          push_valid;
  logic [QW-1:0] push_data;
  logic          push_ready;
  logic          pop_valid;
  logic [QW-1:0] pop_data;
  logic          pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.z_offset <= Z_OFFSET_RST;
      regs.scale    <= SCALE_RST;
      regs.center_x <= CENTER_X_RST;
      regs.center_y <= CENTER_Y_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_Z_OFFSET: regs.z_offset <= $signed(cfg.data[4:0]);
        REG_SCALE:    regs.scale    <= cfg.data;
        REG_CENTER_X: regs.center_x <= cfg.data;
        REG_CENTER_Y: regs.center_y <= cfg.data;
        default: ;
      endcase
    end
  end

  ercp_front #(.AF(ANGLE_FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .src        (src),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  ercp_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  ercp_back #(.AF(ANGLE_FRAC_BITS), .CB(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .dst     (dst)
  );

endmodule

/* rtl/ercp_checker.sv */
// ----------------------------------------------------------------------------
// ercp_checker: port-level checks of the rotated cube projector
// Output ordering, stall hold and reset behavior, bound to the top level.
// ----------------------------------------------------------------------------
module ercp_checker #(
  parameter int CB = 11
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input logic [2:0]    vidx,
  input logic [CB-1:0] sx,
  input logic [CB-1:0] sy,
  input logic          changed,
  input logic          last
);

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (vidx == 3'd7)))
    else $error("last flag does not match vertex 7");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({vidx, sx, sy, changed, last}))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a result right after an accepted one is the next corner
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid || (vidx == 3'($past(vidx) + 3'd1)))
    else $error("vertex results out of order");

endmodule

bind encoder_rotated_cube_projector_unit ercp_checker #(.CB(COORD_BITS)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (dst.valid),
  .out_ready (dst.ready),
  .vidx      (dst.vertex_index),
  .sx        (dst.screen_x),
  .sy        (dst.screen_y),
  .changed   (dst.angle_changed),
  .last      (dst.last)
);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: rotated cube projector check
// Feeds encoder samples: a directed table, then random detent runs and
// noise, across several register settings. A software copy of the angle
// stepping, CORDIC and projection predicts all eight vertices per sample.
// ----------------------------------------------------------------------------
module testbench;
  import ercp_pkg::*;

  localparam int CBITS = 11;
  localparam longint ANG_PI = (longint'(PI_Q60) + (64'sd1 <<< 43)) >>> 44;
  localparam longint ANG_2PI = (longint'(PI_Q60) + (64'sd1 <<< 42)) >>> 43;
  localparam longint ANG_STEP = ((64'sd1 <<< 16) + 2) / 5;
  localparam longint Q30_ONE = 64'sd1 <<< 30;

  typedef struct packed {
    logic [2:0]              vertex;
    logic signed [CBITS-1:0] sx;
    logic signed [CBITS-1:0] sy;
    logic                    changed;
    logic                    last;
  } vertex_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        clk_lvl;
    logic        dt_lvl;
    logic [7:0]  idx;
    logic [7:0]  wdata;
    bit          typed;
    int          x0;
    int          y0;
    bit          chg;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  ercp_in_if             smp_ch ();
  ercp_out_if #(CBITS)   vtx_ch ();
  ercp_cfg_if            cfg_ch ();

  encoder_rotated_cube_projector_unit #(.ANGLE_FRAC_BITS(16), .COORD_BITS(CBITS)) u_top (
    .clk (clk),
    .rst (rst),
    .src (smp_ch),
    .dst (vtx_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // predictor state
  cfg_t    mdl_cfg;
  logic    mdl_prev_clk;
  longint  mdl_angle;
  vertex_t expected_vertices[$];
  int      error_count = 0;
  bit      quiet = 0;
  bit      hold_req = 0;

  longint arctan_tab[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  function automatic void rotate_sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, nx;
    bit     neg;
    a = ang <<< 14;
    x = longint'(CORDIC_GAIN);
    y = 0;
    neg = 0;
    if (a > longint'(HALF_PI_Q30)) begin
      a -= longint'(PI_Q30);
      neg = 1;
    end else if (a < -longint'(HALF_PI_Q30)) begin
      a += longint'(PI_Q30);
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= arctan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += arctan_tab[i];
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  function automatic logic signed [CBITS-1:0] project_coord(input longint centre,
                                                           input longint num,
                                                           input longint den);
    longint maxv, minv, term, p, q;
    maxv = (64'sd1 <<< (CBITS - 1)) - 1;
    minv = -(64'sd1 <<< (CBITS - 1));
    term = num * longint'(mdl_cfg.scale);
    if (den == 0) begin
      q = term > 0 ? maxv : (term < 0 ? minv : centre);
    end else begin
      if (den < 0) begin
        den = -den;
        term = -term;
      end
      p = centre * den + term;
      if (p >= 0) q = (2 * p + den) / (2 * den);
      else q = -((-2 * p + den) / (2 * den));
    end
    if (q > maxv) q = maxv;
    if (q < minv) q = minv;
    return q[CBITS-1:0];
  endfunction

  // step the angle on a falling encoder clock, then queue the eight corners
  function automatic void predict_vertices(input logic cl, input logic dt);
    longint  s, c, vx, vy, vz, den, nx, zo;
    bit      chg;
    vertex_t v;
    chg = 0;
    if (cl != mdl_prev_clk) begin
      mdl_prev_clk = cl;
      if (!cl) begin
        mdl_angle += dt ? ANG_STEP : -ANG_STEP;
        if (mdl_angle >= ANG_PI) mdl_angle -= ANG_2PI;
        if (mdl_angle < -ANG_PI) mdl_angle += ANG_2PI;
        chg = 1;
      end
    end
    rotate_sin_cos(mdl_angle, s, c);
    zo = longint'(mdl_cfg.z_offset);
    for (int k = 0; k < 8; k++) begin
      vx = (k == 0 || k == 3 || k == 4 || k == 7) ? -1 : 1;
      vy = (k == 0 || k == 1 || k == 4 || k == 5) ? -1 : 1;
      vz = (k < 4) ? 1 : -1;
      den = vx * s + vz * c + zo * Q30_ONE;
      nx = vx * c - vz * s;
      v.vertex  = k[2:0];
      v.sx      = project_coord(longint'(mdl_cfg.center_x), nx, den);
      v.sy      = project_coord(longint'(mdl_cfg.center_y), vy * Q30_ONE, den);
      v.changed = chg;
      v.last    = (k == 7);
      expected_vertices.push_back(v);
    end
  endfunction

  function automatic void apply_write(input logic [7:0] idx, input logic [7:0] d);
    case (idx)
      REG_Z_OFFSET: mdl_cfg.z_offset = d[4:0];
      REG_SCALE:    mdl_cfg.scale = d;
      REG_CENTER_X: mdl_cfg.center_x = d;
      REG_CENTER_Y: mdl_cfg.center_y = d;
      default: ;
    endcase
  endfunction

  task automatic send_sample(input logic cl, input logic dt);
    smp_ch.valid     <= 1'b1;
    smp_ch.clk_level <= cl;
    smp_ch.dt_level  <= dt;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    predict_vertices(cl, dt);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      smp_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // only called once the block is idle
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_write(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    logic signed [4:0] zo;
    zo = 5'(-$signed($urandom_range(2, 16)));
    wait_drained();
    write_reg(REG_Z_OFFSET, {3'($urandom), zo});
    write_reg(REG_SCALE, 8'($urandom));
    write_reg(REG_CENTER_X, 8'($urandom));
    write_reg(REG_CENTER_Y, 8'($urandom));
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    vtx_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        vtx_ch.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        vtx_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        vtx_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && vtx_ch.valid && vtx_ch.ready) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex transaction", vtx_ch.vertex_index, -1);
      end else begin
        vertex_t w;
        w = expected_vertices.pop_front();
        if (vtx_ch.vertex_index !== w.vertex)
          report_mismatch("vertex_index", vtx_ch.vertex_index, w.vertex);
        if (vtx_ch.screen_x !== w.sx)
          report_mismatch($sformatf("screen_x v%0d", w.vertex), vtx_ch.screen_x, w.sx);
        if (vtx_ch.screen_y !== w.sy)
          report_mismatch($sformatf("screen_y v%0d", w.vertex), vtx_ch.screen_y, w.sy);
        if (vtx_ch.angle_changed !== w.changed)
          report_mismatch("angle_changed", vtx_ch.angle_changed, w.changed);
        if (vtx_ch.last !== w.last)
          report_mismatch("last", vtx_ch.last, w.last);
      end
    end
  end

  row_t dir_rows[$];

  function automatic row_t mk_sample(input logic cl, input logic dt);
    row_t r;
    r = '{ROW_SAMPLE, cl, dt, 8'd0, 8'd0, 0, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t mk_write(input logic [7:0] idx, input logic [7:0] d);
    row_t r;
    r = '{ROW_WRITE, 1'b0, 1'b0, idx, d, 0, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t mk_typed(input logic cl, input logic dt, input int x0,
                                    input int y0, input bit chg);
    row_t r;
    r = '{ROW_SAMPLE, cl, dt, 8'd0, 8'd0, 1, x0, y0, chg};
    return r;
  endfunction

  initial begin
    int   n_rand;
    bit   dir;
    row_t r;

    rst <= 1'b1;
    smp_ch.valid <= 1'b0;
    smp_ch.clk_level <= 1'b1;
    smp_ch.dt_level <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_Z_OFFSET;
    cfg_ch.data <= 8'd0;
    mdl_cfg = '{Z_OFFSET_RST, SCALE_RST, CENTER_X_RST, CENTER_Y_RST};
    mdl_prev_clk = 1'b1;
    mdl_angle = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; typed rows give vertex 0 screen x and y and the changed flag
    dir_rows = '{
      mk_typed(1'b1, 1'b0, 97, 113, 0),   // reset angle, reset registers
      mk_sample(1'b1, 1'b1),              // level held high: no step
      mk_typed(1'b0, 1'b1, 0, 0, 0),      // falling edge, +0.2 rad
      mk_sample(1'b0, 1'b0),              // held low: no step
      mk_sample(1'b1, 1'b0),              // rising edge: level only
      mk_sample(1'b0, 1'b0),              // falling edge, -0.2 rad
      mk_sample(1'b1, 1'b1),
      mk_sample(1'b0, 1'b0),
      mk_write(REG_SCALE, 8'd0),
      mk_write(REG_CENTER_X, 8'd255),
      mk_write(REG_CENTER_Y, 8'd255),
      mk_typed(1'b1, 1'b0, 255, 255, 0),  // zero scale lands on centre
      mk_write(REG_Z_OFFSET, 8'h10),      // -16, farthest
      mk_write(REG_SCALE, 8'd255),
      mk_write(REG_CENTER_X, 8'd0),
      mk_write(REG_CENTER_Y, 8'd0),
      mk_sample(1'b0, 1'b1),
      mk_sample(1'b1, 1'b1),
      mk_write(REG_Z_OFFSET, 8'hFE),      // -2, nearest, upper bits set
      mk_write(REG_CENTER_X, 8'd128),
      mk_write(8'd4, 8'd77),              // index past the list: ignored
      mk_write(8'd255, 8'd0),
      mk_sample(1'b0, 1'b1),
      mk_sample(1'b1, 1'b0),
      mk_sample(1'b0, 1'b0)
    };
    // the second typed row is checked as a plain sample against the predictor
    dir_rows[2].typed = 0;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_WRITE) begin
        wait_drained();
        write_reg(r.idx, r.wdata);
      end else begin
        send_sample(r.clk_lvl, r.dt_lvl);
        if (r.typed) begin
          expected_vertices[expected_vertices.size()-8].sx = r.x0[CBITS-1:0];
          expected_vertices[expected_vertices.size()-8].sy = r.y0[CBITS-1:0];
          expected_vertices[expected_vertices.size()-8].changed = r.chg;
        end
      end
    end

    // random part: mostly detent runs in one direction, long enough to wrap
    n_rand = 0;
    hold_req = 1;
    while (n_rand < 160) begin
      if (n_rand % 40 == 0 && n_rand != 0) random_config();
      if (n_rand >= 130) quiet = 1;
      if ($urandom_range(0, 9) < 7) begin
        dir = $urandom_range(0, 1);
        repeat ($urandom_range(1, 20)) begin
          send_sample(1'b0, dir ^ ($urandom_range(0, 15) == 0));
          send_sample(1'b1, 1'($urandom));
          n_rand += 2;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_sample(1'($urandom), 1'($urandom));
          n_rand++;
        end
      end
    end

    smp_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
